@@ hw/rtl/mcsa_pkg.sv @@
// mcsa_pkg: shared types, codes and fixed-point constants of the motion command source arbiter
// used by mcsa_cordic and motion_command_source_arbiter; depends on nothing
package mcsa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int VAL_W     = 20;
   localparam int DIR_W     = 17;
   localparam int SRC_W     = 3;
   localparam int FMT_W     = 2;
   localparam int FS_W      = 19;
   localparam int CNT_W     = 8;
   localparam int CSR_IDX_W = 3;

   // cordic datapath
   localparam int GUARD    = 8;
   localparam int ANG_FRAC = 24;
   localparam int XW       = 31;
   localparam int ZW       = 35;
   localparam int ITER_W   = 5;

   localparam int HUNDRED       = 100 << FRAC_BITS;
   localparam int GAIN_MIN_HOLD = 10 << FRAC_BITS;
   localparam int HALF_TURN     = 180 << FRAC_BITS;
   localparam int VAL_MAX       = 524287;
   localparam longint INV_GAIN_Q30 = 64'd652032874;
   localparam int MAG_SHIFT     = 30 + GUARD;

   // floor(v / HUNDRED) after a shift by FRAC_BITS: v / 100 by reciprocal, exact below 2^26
   localparam int     RCP_IN_W  = 26;
   localparam int     RCP_SHIFT = 33;
   localparam longint RCP_MAGIC = 64'd85899346;

   localparam logic [SRC_W-1:0] SRC_JOY0 = 3'd0;
   localparam logic [SRC_W-1:0] SRC_JOY1 = 3'd1;
   localparam logic [SRC_W-1:0] SRC_ROS  = 3'd2 + 3'd1;

   typedef enum logic {
      REQ_TICK = 1'b0,
      REQ_CMD  = 1'b1
   } req_kind_type;

   localparam logic [FMT_W-1:0] FMT_INVALID = 2'd0;
   localparam logic [FMT_W-1:0] FMT_PCT     = 2'd1;
   localparam logic [FMT_W-1:0] FMT_SPEED   = 2'd2;
   localparam logic [FMT_W-1:0] FMT_CART    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_LIN_FS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANG_FS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROS_EN  = 3'd4;

   // atan(2^-i) in degrees, 24 fraction bits
   function automatic logic signed [ZW-1:0] atan_deg(input logic [ITER_W-1:0] i);
      logic signed [ZW-1:0] r;
      case (i)
         5'd0:  r = 35'sd754974720;
         5'd1:  r = 35'sd445687602;
         5'd2:  r = 35'sd235489088;
         5'd3:  r = 35'sd119537938;
         5'd4:  r = 35'sd60000934;
         5'd5:  r = 35'sd30029717;
         5'd6:  r = 35'sd15018523;
         5'd7:  r = 35'sd7509720;
         5'd8:  r = 35'sd3754917;
         5'd9:  r = 35'sd1877466;
         5'd10: r = 35'sd938734;
         5'd11: r = 35'sd469367;
         5'd12: r = 35'sd234684;
         5'd13: r = 35'sd117342;
         5'd14: r = 35'sd58671;
         5'd15: r = 35'sd29335;
         5'd16: r = 35'sd14668;
         5'd17: r = 35'sd7334;
         5'd18: r = 35'sd3667;
         5'd19: r = 35'sd1833;
         5'd20: r = 35'sd917;
         5'd21: r = 35'sd458;
         5'd22: r = 35'sd229;
         5'd23: r = 35'sd115;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/mcsa_cordic.sv @@
// mcsa_cordic: iterative cordic vectoring, one micro-rotation per cycle
// depends on mcsa_pkg for widths and the angle table
module mcsa_cordic import mcsa_pkg::*; #(
   parameter int ITERS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [VAL_W-1:0] a,
   input  logic signed [VAL_W-1:0] b,
   output logic                    done,
   output logic signed [XW-1:0]    x_out,
   output logic signed [ZW-1:0]    z_out
);

   localparam int CW = (ITERS > 1) ? $clog2(ITERS) : 1;
   localparam logic [CW-1:0] LAST = CW'(ITERS - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        iter_ff, iter_in;
   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in, ax, bx, dx, dy;
   logic signed [ZW-1:0] z_ff, z_in, half_turn_q24;

   assign ax = XW'(a);
   assign bx = XW'(b);
   assign half_turn_q24 = ZW'(180) <<< ANG_FRAC;
   assign dx = y_ff >>> iter_ff;
   assign dy = x_ff >>> iter_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         // left half plane: rotate by half a turn first
         if (a < 0) begin
            x_in = (-ax) <<< GUARD;
            y_in = (-bx) <<< GUARD;
            z_in = (b >= 0) ? half_turn_q24 : -half_turn_q24;
         end else begin
            x_in = ax <<< GUARD;
            y_in = bx <<< GUARD;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_deg(ITER_W'(iter_ff));
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_deg(ITER_W'(iter_ff));
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign z_out = z_ff;

   assert property (@(posedge clock) disable iff (reset) start |=> busy_ff)
      else $error("cordic did not start");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("cordic done while busy");
   assert property (@(posedge clock) disable iff (reset) (busy_ff && iter_ff == LAST) |=> done_ff)
      else $error("cordic missed its last iteration");

endmodule

@@ hw/rtl/motion_command_source_arbiter.sv @@
// motion_command_source_arbiter: top level, per-source command store, tick arbitration
// depends on mcsa_pkg and mcsa_cordic
//
// A tick transaction waits while a command is in progress or an earlier result is still
// stalled; once taken, its result is registered on the rsp side the next cycle. A command
// transaction keeps the block busy while one shared 32x32 multiplier and the cordic work:
// polar commands go straight to the write state, joystick polar commands first make two
// multiply, reciprocal and finish passes, nonzero Cartesian commands run the cordic and
// round the magnitude, plus the same passes for joysticks; ignored commands leave it idle.
module motion_command_source_arbiter import mcsa_pkg::*; #(
   parameter int NUM_SOURCES  = 5,
   parameter int CORDIC_ITERS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_type,
   input  logic [SRC_W-1:0]        req_source,
   input  logic [FMT_W-1:0]        req_cmd_format,
   input  logic signed [VAL_W-1:0] req_val_a,
   input  logic signed [VAL_W-1:0] req_val_b,
   input  logic signed [VAL_W-1:0] req_val_c,
   input  logic signed [VAL_W-1:0] req_val_gain,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [DIR_W-1:0] rsp_direction,
   output logic signed [VAL_W-1:0] rsp_lin_speed,
   output logic signed [VAL_W-1:0] rsp_ang_speed,
   output logic signed [VAL_W-1:0] rsp_drive_gain,
   output logic [SRC_W-1:0]        rsp_active_source,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [FS_W-1:0]         csr_wdata
);

   localparam int NH = NUM_SOURCES - 1;
   localparam logic [SRC_W-1:0] SRC_LAST = SRC_W'(NUM_SOURCES - 1);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CORDIC = 7'b0000010,
      ST_MAGR   = 7'b0000100,
      ST_JMUL   = 7'b0001000,
      ST_JRCP   = 7'b0010000,
      ST_JFIN   = 7'b0100000,
      ST_WRITE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [FS_W-1:0]  lin_fs_ff, ang_fs_ff;
   logic [CNT_W-1:0] timeout_ff, hold_ticks_ff;
   logic             ros_en_ff;

   // per-source store
   logic signed [VAL_W-1:0] dir_mem_ff [NUM_SOURCES];
   logic signed [VAL_W-1:0] lin_mem_ff [NUM_SOURCES];
   logic signed [VAL_W-1:0] ang_mem_ff [NUM_SOURCES];
   logic signed [VAL_W-1:0] gain_mem_ff[NUM_SOURCES];
   logic [CNT_W-1:0]        age_ff     [NUM_SOURCES];
   logic [CNT_W-1:0]        hold_ff    [NH];

   // working registers of one command
   logic [SRC_W-1:0]        src_ff, src_in;
   logic signed [VAL_W-1:0] dir_ff, dir_in, lin_ff, lin_in, c_ff, c_in, g_ff, g_in;
   logic                    jsel_ff, jsel_in, jneg_ff, jneg_in;
   logic [63:0]             prod_ff, prod_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [DIR_W-1:0] o_dir_ff;
   logic signed [VAL_W-1:0] o_lin_ff, o_ang_ff, o_gain_ff;
   logic [SRC_W-1:0]        o_src_ff;

   logic accept, tick_acc, cmd_acc, cmd_ignored, is_joy, cart_zero;
   logic cordic_start, cordic_done;
   logic signed [XW-1:0] cordic_x;
   logic signed [ZW-1:0] cordic_z, z_round;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p, mag_sum, rcp_sum;
   logic signed [VAL_W-1:0] j_val, j_clamp, j_res, a_clamp, g_clamp;
   logic [VAL_W-1:0]        j_abs;
   logic [RCP_IN_W-1:0]     rcp_in;
   logic [VAL_W-1:0]        j_q;
   logic [SRC_W-1:0]        sel;
   logic [CNT_W-1:0]        age_next[NUM_SOURCES];

   assign req_stall = (state_ff != ST_IDLE) ||
                      (req_type == REQ_TICK && rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign tick_acc  = accept && req_type == REQ_TICK;
   assign cmd_acc   = accept && req_type == REQ_CMD;
   assign cmd_ignored = (req_source > SRC_LAST) || (req_cmd_format == FMT_INVALID) ||
                        (req_source == SRC_ROS && !ros_en_ff);
   assign cart_zero = (req_val_a == '0) && (req_val_b == '0);
   assign cordic_start = cmd_acc && !cmd_ignored && req_cmd_format == FMT_CART && !cart_zero;
   assign is_joy = (src_ff == SRC_JOY0) || (src_ff == SRC_JOY1);

   mcsa_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .a     (req_val_a),
      .b     (req_val_b),
      .done  (cordic_done),
      .x_out (cordic_x),
      .z_out (cordic_z)
   );

   // input clamps for polar commands
   always_comb begin
      if (req_val_a > VAL_W'(HALF_TURN))       a_clamp = VAL_W'(HALF_TURN);
      else if (req_val_a < -VAL_W'(HALF_TURN)) a_clamp = -VAL_W'(HALF_TURN);
      else                                     a_clamp = req_val_a;
      if (req_val_gain > VAL_W'(HUNDRED))      g_clamp = VAL_W'(HUNDRED);
      else if (req_val_gain < 0)               g_clamp = '0;
      else                                     g_clamp = req_val_gain;
   end

   // joystick scaling operand
   assign j_val = jsel_ff ? c_ff : lin_ff;
   always_comb begin
      if (j_val > VAL_W'(HUNDRED))       j_clamp = VAL_W'(HUNDRED);
      else if (j_val < -VAL_W'(HUNDRED)) j_clamp = -VAL_W'(HUNDRED);
      else                               j_clamp = j_val;
   end
   assign j_abs   = (j_clamp < 0) ? VAL_W'(-j_clamp) : VAL_W'(j_clamp);
   assign rcp_sum = prod_ff + 64'(HUNDRED / 2);
   assign rcp_in  = rcp_sum[FRAC_BITS +: RCP_IN_W];
   assign j_q     = prod_ff[RCP_SHIFT +: VAL_W];
   assign j_res   = jneg_ff ? -$signed(j_q) : $signed(j_q);

   // cordic angle rounding to FRAC_BITS
   assign z_round = (cordic_z + (ZW'(1) <<< (ANG_FRAC - FRAC_BITS - 1))) >>>
                    (ANG_FRAC - FRAC_BITS);
   assign mag_sum = prod_ff + (64'd1 << (MAG_SHIFT - 1));

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_CORDIC) begin
         mul_a = (cordic_x < 0) ? '0 : 32'(cordic_x);
         mul_b = 32'(INV_GAIN_Q30);
      end else if (state_ff == ST_JMUL) begin
         mul_a = 32'(j_abs);
         mul_b = jsel_ff ? 32'(ang_fs_ff) : 32'(lin_fs_ff);
      end else if (state_ff == ST_JRCP) begin
         mul_a = 32'(rcp_in);
         mul_b = 32'(RCP_MAGIC);
      end
   end
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      state_in = state_ff;
      src_in   = src_ff;
      dir_in   = dir_ff;
      lin_in   = lin_ff;
      c_in     = c_ff;
      g_in     = g_ff;
      jsel_in  = jsel_ff;
      jneg_in  = jneg_ff;
      prod_in  = prod_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_acc && !cmd_ignored) begin
               src_in  = req_source;
               c_in    = req_val_c;
               jsel_in = 1'b0;
               if (req_cmd_format == FMT_CART) begin
                  g_in   = req_val_gain;
                  dir_in = '0;
                  lin_in = '0;
                  state_in = cart_zero ? ST_WRITE : ST_CORDIC;
                  if (cart_zero && (req_source == SRC_JOY0 || req_source == SRC_JOY1))
                     state_in = ST_JMUL;
               end else begin
                  g_in   = g_clamp;
                  dir_in = a_clamp;
                  lin_in = req_val_b;
                  state_in = (req_source == SRC_JOY0 || req_source == SRC_JOY1) ?
                             ST_JMUL : ST_WRITE;
               end
            end
         end
         ST_CORDIC: begin
            if (cordic_done) begin
               if (z_round > ZW'(HALF_TURN))       dir_in = VAL_W'(HALF_TURN);
               else if (z_round < -ZW'(HALF_TURN)) dir_in = -VAL_W'(HALF_TURN);
               else                                dir_in = VAL_W'(z_round);
               prod_in  = mul_p;
               state_in = ST_MAGR;
            end
         end
         ST_MAGR: begin
            if ((mag_sum >> MAG_SHIFT) > 64'(VAL_MAX)) lin_in = VAL_W'(VAL_MAX);
            else lin_in = VAL_W'(mag_sum >> MAG_SHIFT);
            state_in = is_joy ? ST_JMUL : ST_WRITE;
         end
         ST_JMUL: begin
            prod_in  = mul_p;
            jneg_in  = j_clamp < 0;
            state_in = ST_JRCP;
         end
         ST_JRCP: begin
            prod_in  = mul_p;
            state_in = ST_JFIN;
         end
         ST_JFIN: begin
            if (jsel_ff) begin
               c_in     = j_res;
               state_in = ST_WRITE;
            end else begin
               lin_in   = j_res;
               jsel_in  = 1'b1;
               state_in = ST_JMUL;
            end
         end
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // priority pick: lowest held source, else the last source (SRC_LAST)
   always_comb begin
      sel = SRC_LAST;
      for (int s = NH - 1; s >= 0; s--) begin
         if (hold_ff[s] != '0) sel = SRC_W'(s);
      end
   end

   always_comb begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
         age_next[s] = (age_ff[s] == '1) ? age_ff[s] : age_ff[s] + 1'b1;
      end
   end

   assign rsp_valid_in = tick_acc ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         lin_fs_ff     <= '0;
         ang_fs_ff     <= '0;
         timeout_ff    <= CNT_W'(10);
         hold_ticks_ff <= CNT_W'(100);
         ros_en_ff     <= 1'b0;
         for (int s = 0; s < NUM_SOURCES; s++) begin
            dir_mem_ff[s]  <= '0;
            lin_mem_ff[s]  <= '0;
            ang_mem_ff[s]  <= '0;
            gain_mem_ff[s] <= '0;
            age_ff[s]      <= '0;
         end
         for (int s = 0; s < NH; s++) hold_ff[s] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_LIN_FS:  lin_fs_ff     <= csr_wdata;
               CSR_ANG_FS:  ang_fs_ff     <= csr_wdata;
               CSR_TIMEOUT: timeout_ff    <= csr_wdata[CNT_W-1:0];
               CSR_HOLD:    hold_ticks_ff <= csr_wdata[CNT_W-1:0];
               CSR_ROS_EN:  ros_en_ff     <= csr_wdata[0];
               default: ;
            endcase
         end
         if (tick_acc) begin
            for (int s = 0; s < NUM_SOURCES; s++) begin
               age_ff[s] <= age_next[s];
               if (age_next[s] > timeout_ff) begin
                  dir_mem_ff[s]  <= '0;
                  lin_mem_ff[s]  <= '0;
                  ang_mem_ff[s]  <= '0;
                  gain_mem_ff[s] <= '0;
               end
            end
            for (int s = 0; s < NH; s++) begin
               if (hold_ff[s] != '0) hold_ff[s] <= hold_ff[s] - 1'b1;
            end
         end else if (state_ff == ST_WRITE) begin
            for (int s = 0; s < NUM_SOURCES; s++) begin
               if (src_ff == SRC_W'(s)) begin
                  dir_mem_ff[s]  <= dir_ff;
                  lin_mem_ff[s]  <= lin_ff;
                  ang_mem_ff[s]  <= c_ff;
                  gain_mem_ff[s] <= g_ff;
                  age_ff[s]      <= '0;
               end
            end
            // joysticks take priority only above the minimum gain
            for (int s = 0; s < NH; s++) begin
               if (src_ff == SRC_W'(s) && (!is_joy || g_ff > VAL_W'(GAIN_MIN_HOLD)))
                  hold_ff[s] <= hold_ticks_ff;
            end
         end
      end
      src_ff  <= src_in;
      dir_ff  <= dir_in;
      lin_ff  <= lin_in;
      c_ff    <= c_in;
      g_ff    <= g_in;
      jsel_ff <= jsel_in;
      jneg_ff <= jneg_in;
      prod_ff <= prod_in;
      if (tick_acc) begin
         o_dir_ff  <= DIR_W'(dir_mem_ff[sel]);
         o_lin_ff  <= lin_mem_ff[sel];
         o_ang_ff  <= ang_mem_ff[sel];
         o_gain_ff <= gain_mem_ff[sel];
         o_src_ff  <= sel;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_direction     = o_dir_ff;
   assign rsp_lin_speed     = o_lin_ff;
   assign rsp_ang_speed     = o_ang_ff;
   assign rsp_drive_gain    = o_gain_ff;
   assign rsp_active_source = o_src_ff;

   assert property (@(posedge clock) disable iff (reset) (state_ff != ST_IDLE) |-> req_stall)
      else $error("transaction taken while a command is in progress");
   assert property (@(posedge clock) disable iff (reset) tick_acc |=> rsp_valid)
      else $error("tick gave no result");
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(tick_acc))
      else $error("result without a tick");
   assert property (@(posedge clock) disable iff (reset) cordic_done |-> state_ff == ST_CORDIC)
      else $error("cordic finished outside its state");

endmodule
